// ===== rtl/bsl_pkg.sv =====
package bsl_pkg;

    // Built size of the store and width of a stored value
    localparam int CAPACITY_DEFAULT    = 16;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // Fixed field widths of the ports
    localparam int OP_W     = 3;
    localparam int POS_W    = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 5;
    localparam int APB_AW   = 2;
    localparam int APB_DW   = 32;

    // Byte address of the entry limit register
    localparam logic [APB_AW-1:0] REG_LIST_LIMIT = APB_AW'(0);

    // Reset value of the entry limit register
    localparam logic [LEN_W-1:0] LIST_LIMIT_RESET = LEN_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_DELETE = 3'd1,
        OP_READ   = 3'd2,
        OP_WRITE  = 3'd3,
        OP_SEARCH = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_RANGE     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WRAP
    } state_t;

endpackage

// ===== rtl/bsl_cell.sv =====
module bsl_cell #(
    parameter int VALUE_WIDTH = bsl_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   shift,
    input  logic                   replace,
    input  logic [VALUE_WIDTH-1:0] din,
    input  logic [VALUE_WIDTH-1:0] wdata,
    output logic [VALUE_WIDTH-1:0] q
);
    import bsl_pkg::*;

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;

    // Take the neighbor's entry, or the new value when this slot is rewritten
    always_comb
    begin
        value_next = replace ? wdata : din;
    end

    // Hold the entry unless the ring advances
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= value_next;
        end
    end

    assign q = value_reg;

endmodule

// ===== rtl/bounded_sequential_list_core.sv =====
// Bounded sequential list. The entries sit in a ring of CAPACITY cells;
// every operation (append, delete last, read, write, search, clear)
// rotates the ring once around, so entry k passes the head cell at
// step k of the pass, where it is compared, captured or replaced.
// An item is accepted while idle, then the ring rotates through all
// CAPACITY cells and the result is posted; no new transaction is taken
// until the pass is over and its result is in the output register.
// The result sits in an output register; a new item may be accepted while
// it waits, and a finished pass holds until that register is free.
// list_limit (APB offset 0, reset 16) caps the number of entries in use;
// lowering it below the current length keeps existing entries.
// Entries are not cleared at reset and need no clearing pass.
module bounded_sequential_list_core #(
    parameter int CAPACITY    = bsl_pkg::CAPACITY_DEFAULT,
    parameter int VALUE_WIDTH = bsl_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bsl_pkg::APB_AW-1:0]   paddr,
    input  logic [bsl_pkg::APB_DW-1:0]   pwdata,
    output logic [bsl_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    // input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bsl_pkg::OP_W-1:0]     operation,
    input  logic [bsl_pkg::POS_W-1:0]    position,
    input  logic [bsl_pkg::DATA_W-1:0]   item_value,
    // output channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bsl_pkg::STATUS_W-1:0] status,
    output logic [bsl_pkg::DATA_W-1:0]   read_value,
    output logic [bsl_pkg::POS_W-1:0]    found_position,
    output logic [bsl_pkg::LEN_W-1:0]    current_length,
    output logic                         is_empty
);
    import bsl_pkg::*;

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int SW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int WW0 = (CW > LEN_W) ? CW : LEN_W;
    localparam int WW  = (WW0 > POS_W) ? WW0 : POS_W;
    localparam logic [SW-1:0] LAST_STEP = SW'(CAPACITY - 1);

    state_t                 state_reg, state_next;
    logic [SW-1:0]          step_reg, step_next;
    op_t                    op_reg, op_next;
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [SW-1:0]          target_reg, target_next;
    logic                   wr_ok_reg, wr_ok_next;
    logic                   rd_ok_reg, rd_ok_next;
    logic                   found_reg, found_next;
    logic [SW-1:0]          fpos_reg, fpos_next;
    logic [VALUE_WIDTH-1:0] hold_reg, hold_next;
    status_t                stat_reg, stat_next;
    logic [CW-1:0]          used_reg, used_next;
    logic [LEN_W-1:0]       limit_reg, limit_next;

    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [DATA_W-1:0]      out_value_reg, out_value_next;
    logic [POS_W-1:0]       out_fpos_reg, out_fpos_next;
    logic [LEN_W-1:0]       out_len_reg, out_len_next;
    logic                   out_empty_reg, out_empty_next;

    logic                   in_fire;
    logic                   out_free;
    logic                   shift;
    logic                   wr_hit;
    logic                   rd_hit;
    logic                   search_hit;
    logic [VALUE_WIDTH-1:0] in_ext;
    logic [DATA_W-1:0]      hold_ext;
    logic [VALUE_WIDTH-1:0] head;
    logic [WW-1:0]          used_w, pos_w, cap_w, lim_raw, lim_w, step_w, tgt_w, fpos_w;
    logic                   acc_ok;
    logic [CW-1:0]          used_done;
    status_t                stat_done;

    logic [VALUE_WIDTH-1:0] cell_q   [CAPACITY];
    logic [VALUE_WIDTH-1:0] cell_din [CAPACITY];

    // Ring of cells: each takes its upper neighbor, the top one takes the head
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == CAPACITY - 1)
        begin : g_top
            assign cell_din[i] = cell_q[0];
        end
        else
        begin : g_mid
            assign cell_din[i] = cell_q[i + 1];
        end

        bsl_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk     (clk),
            .shift   (shift),
            .replace ((i == CAPACITY - 1) && wr_hit),
            .din     (cell_din[i]),
            .wdata   (key_reg),
            .q       (cell_q[i])
        );
    end

    assign head = cell_q[0];

    // Sign-extend the input value to the stored width
    always_comb
    begin
        for (int b = 0; b < VALUE_WIDTH; b++)
        begin
            in_ext[b] = (b < DATA_W) ? item_value[b] : item_value[DATA_W-1];
        end
    end

    // Sign-extend a stored value to the port width
    always_comb
    begin
        for (int b = 0; b < DATA_W; b++)
        begin
            hold_ext[b] = (b < VALUE_WIDTH) ? hold_reg[b] : hold_reg[VALUE_WIDTH-1];
        end
    end

    // Handshake and pass control
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign shift    = (state_reg == S_RUN);
    assign step_w   = WW'(step_reg);
    assign used_w   = WW'(used_reg);
    assign wr_hit   = shift && wr_ok_reg && (step_reg == target_reg);
    assign rd_hit   = shift && rd_ok_reg && (step_reg == target_reg);
    assign search_hit = shift && (op_reg == OP_SEARCH) && !found_reg
                        && (step_w < used_w) && (head == key_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_RUN:   in_ready = 1'b0;
            S_WRAP:  in_ready = 1'b0;
            default: in_ready = 1'b0;
        endcase
    end

    // Decide bounds at accept
    always_comb
    begin
        pos_w   = WW'(position);
        cap_w   = WW'(CAPACITY);
        lim_raw = WW'(limit_reg);
        lim_w   = (lim_raw < cap_w) ? lim_raw : cap_w;
        acc_ok  = 1'b0;
        tgt_w   = '0;
        wr_ok_next = 1'b0;
        rd_ok_next = 1'b0;
        stat_next  = ST_OK;
        case (operation)
            OP_APPEND:
            begin
                acc_ok     = (used_w < lim_w) && (used_w < cap_w);
                tgt_w      = used_w;
                wr_ok_next = acc_ok;
                stat_next  = acc_ok ? ST_OK : ST_FULL;
            end
            OP_DELETE:
            begin
                acc_ok     = (used_w != '0);
                tgt_w      = used_w - WW'(1);
                rd_ok_next = acc_ok;
                stat_next  = acc_ok ? ST_OK : ST_EMPTY;
            end
            OP_READ:
            begin
                acc_ok     = (pos_w < used_w) && (pos_w < cap_w);
                tgt_w      = pos_w;
                rd_ok_next = acc_ok;
                stat_next  = acc_ok ? ST_OK : ST_RANGE;
            end
            OP_WRITE:
            begin
                acc_ok     = (pos_w < used_w) && (pos_w < cap_w);
                tgt_w      = pos_w;
                wr_ok_next = acc_ok;
                stat_next  = acc_ok ? ST_OK : ST_RANGE;
            end
            default:
            begin
                stat_next = ST_OK;
            end
        endcase
        target_next = tgt_w[SW-1:0];
        op_next     = op_t'(operation);
        key_next    = in_ext;
    end

    // Length and status once the pass is over
    always_comb
    begin
        used_done = used_reg;
        stat_done = stat_reg;
        case (op_reg)
            OP_APPEND:
            begin
                if (wr_ok_reg)
                begin
                    used_done = used_reg + CW'(1);
                end
            end
            OP_DELETE:
            begin
                if (rd_ok_reg)
                begin
                    used_done = used_reg - CW'(1);
                end
            end
            OP_SEARCH:
            begin
                stat_done = found_reg ? ST_OK : ST_NOT_FOUND;
            end
            OP_CLEAR:
            begin
                used_done = '0;
            end
            default:
            begin
                used_done = used_reg;
            end
        endcase
    end

    // Register updates for the pass and the output stage
    always_comb
    begin
        step_next  = step_reg;
        found_next = found_reg;
        fpos_next  = fpos_reg;
        hold_next  = hold_reg;
        used_next  = used_reg;
        fpos_w     = WW'(fpos_reg);

        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_fpos_next   = out_fpos_reg;
        out_len_next    = out_len_reg;
        out_empty_next  = out_empty_reg;

        if (in_fire)
        begin
            step_next  = '0;
            found_next = 1'b0;
            fpos_next  = '0;
            hold_next  = '0;
        end

        // Advance the ring and watch the head
        if (shift)
        begin
            step_next = step_reg + SW'(1);
            if (rd_hit)
            begin
                hold_next = head;
            end
            if (search_hit)
            begin
                found_next = 1'b1;
                fpos_next  = step_reg;
            end
        end

        // Post the result and commit the new length
        if (state_reg == S_WRAP && out_free)
        begin
            used_next       = used_done;
            out_valid_next  = 1'b1;
            out_status_next = stat_done;
            out_value_next  = hold_ext;
            out_fpos_next   = fpos_w[POS_W-1:0];
            out_len_next    = LEN_W'(used_done);
            out_empty_next  = (used_done == '0);
        end
    end

    // Configuration write
    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && pready)
        begin
            limit_next = pwdata[LEN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_LIST_LIMIT) ? APB_DW'(limit_reg) : '0;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            used_reg      <= '0;
            limit_reg     <= LIST_LIMIT_RESET;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            used_reg      <= used_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        fpos_reg <= fpos_next;
        hold_reg <= hold_next;
        if (in_fire)
        begin
            op_reg     <= op_next;
            key_reg    <= key_next;
            target_reg <= target_next;
            wr_ok_reg  <= wr_ok_next;
            rd_ok_reg  <= rd_ok_next;
            stat_reg   <= stat_next;
        end
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_fpos_reg   <= out_fpos_next;
        out_len_reg    <= out_len_next;
        out_empty_reg  <= out_empty_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign read_value     = out_value_reg;
    assign found_position = out_fpos_reg;
    assign current_length = out_len_reg;
    assign is_empty       = out_empty_reg;

endmodule

// ===== rtl/bsl_checker.sv =====
module bsl_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [bsl_pkg::STATUS_W-1:0] status,
    input logic [bsl_pkg::DATA_W-1:0]   read_value,
    input logic [bsl_pkg::LEN_W-1:0]    current_length,
    input logic                         is_empty
);
    import bsl_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_value))
        else $error("result changed while stalled");

    // The empty flag follows the length
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (current_length == '0)))
        else $error("empty flag disagrees with length");

    // Status codes stay in range
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= STATUS_W'(ST_NOT_FOUND)))
        else $error("status code out of range");

    // One transaction at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a pass is running");

endmodule

bind bounded_sequential_list_core bsl_checker u_bsl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .read_value     (read_value),
    .current_length (current_length),
    .is_empty       (is_empty)
);
